FILE: rtl/mvd_pkg.sv
package mvd_pkg;

   localparam int SUB_BLOCKS          = 4;
   localparam int MAX_PREFIX_ONES_DEF = 27;

   localparam logic [5:0]  CTX_BASE_X     = 6'd40;
   localparam logic [5:0]  CTX_BASE_Y     = 6'd47;
   localparam logic [4:0]  UEG_ORDER      = 5'd3;
   localparam logic [4:0]  TU_EXTRA       = 5'd8;
   localparam logic [6:0]  ABS_LIMIT_LOW  = 7'd3;
   localparam logic [6:0]  ABS_LIMIT_HIGH = 7'd32;
   localparam logic [5:0]  ABS_SAT        = 6'd33;
   localparam logic [31:0] UEG_OFFSET     = 32'd9;
   localparam logic [31:0] VALUE_MAX      = 32'h7FFF_FFFF;

   localparam logic ACT_BEGIN = 1'b0;
   localparam logic ACT_BIN   = 1'b1;

   // absolute mvd component, saturated just above the largest threshold
   typedef logic [5:0] abs_type;

   typedef struct packed {
      logic [1:0] sub;
      logic       axis;
      logic       type_zero;
   } nbr_query_type;

   typedef struct packed {
      logic       en;
      logic [1:0] sub;
      abs_type    x_abs;
      abs_type    y_abs;
   } nbr_write_type;

   typedef struct packed {
      logic [5:0]         next_ctx;
      logic               next_bypass;
      logic               mvd_valid;
      logic signed [31:0] mvd_value;
      logic               mvd_axis;
      logic [1:0]         sub_block;
      logic [1:0]         part_index;
      logic               error_flag;
      logic               last;
   } rsp_type;

   function automatic logic [5:0] tu_offset(input logic [2:0] idx);
      logic [5:0] r;
      case (idx)
         3'd0:    r = 6'd3;
         3'd1:    r = 6'd4;
         3'd2:    r = 6'd5;
         default: r = 6'd6;
      endcase
      return r;
   endfunction

   function automatic abs_type sat_abs(input logic [31:0] v);
      return (v > {26'd0, ABS_SAT}) ? ABS_SAT : v[5:0];
   endfunction

   function automatic logic [2:0] parts_of(input logic [1:0] t);
      logic [2:0] r;
      case (t)
         2'd0:    r = 3'd1;
         2'd3:    r = 3'd4;
         default: r = 3'd2;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] type_of(input logic [7:0] types, input logic [1:0] sub);
      logic [1:0] r;
      case (sub)
         2'd0:    r = types[1:0];
         2'd1:    r = types[3:2];
         2'd2:    r = types[5:4];
         default: r = types[7:6];
      endcase
      return r;
   endfunction

   function automatic logic [5:0] ctx_base(input logic axis);
      return axis ? CTX_BASE_Y : CTX_BASE_X;
   endfunction

endpackage

FILE: rtl/mvd_nbr.sv
module mvd_nbr
   import mvd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          clear,
   input  nbr_write_type wr,
   input  nbr_query_type query,
   output logic [1:0]    inc
);

   logic [SUB_BLOCKS-1:0] valid_ff;
   logic [SUB_BLOCKS-1:0] valid_in;
   abs_type               x_abs_ff [SUB_BLOCKS];
   abs_type               y_abs_ff [SUB_BLOCKS];

   // entry as seen this cycle, with the write in flight forwarded
   logic [SUB_BLOCKS-1:0] eff_valid;
   abs_type               eff_abs [SUB_BLOCKS];
   logic [6:0]            sum;

   always_comb begin
      if (clear) begin
         valid_in = '0;
      end else begin
         valid_in = valid_ff;
         if (wr.en) begin
            valid_in[wr.sub] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         x_abs_ff[wr.sub] <= wr.x_abs;
         y_abs_ff[wr.sub] <= wr.y_abs;
      end
   end

   always_comb begin
      for (int n = 0; n < SUB_BLOCKS; n++) begin
         if (wr.en && (wr.sub == 2'(n))) begin
            eff_valid[n] = 1'b1;
            eff_abs[n]   = query.axis ? wr.y_abs : wr.x_abs;
         end else begin
            eff_valid[n] = valid_ff[n];
            eff_abs[n]   = query.axis ? y_abs_ff[n] : x_abs_ff[n];
         end
      end
   end

   // left neighbor is sub-1 for odd subs, top neighbor is sub-2 for the lower row
   always_comb begin
      case (query.sub)
         2'd1:    sum = eff_valid[0] ? {1'b0, eff_abs[0]} : 7'd0;
         2'd2:    sum = eff_valid[0] ? {1'b0, eff_abs[0]} : 7'd0;
         2'd3:    sum = (eff_valid[2] ? {1'b0, eff_abs[2]} : 7'd0)
                      + (eff_valid[1] ? {1'b0, eff_abs[1]} : 7'd0);
         default: sum = 7'd0;
      endcase
      if (!query.type_zero || (sum < ABS_LIMIT_LOW)) begin
         inc = 2'd0;
      end else if (sum <= ABS_LIMIT_HIGH) begin
         inc = 2'd1;
      end else begin
         inc = 2'd2;
      end
   end

endmodule

FILE: rtl/mvd_ctrl.sv
module mvd_ctrl
   import mvd_pkg::*;
#(
   parameter int MAX_PREFIX_ONES = MAX_PREFIX_ONES_DEF
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          accept,
   input  logic          action,
   input  logic [7:0]    sub_types,
   input  logic [2:0]    sub_count,
   input  logic          bin_value,
   input  logic [1:0]    inc,
   output nbr_query_type query,
   output nbr_write_type wr,
   output logic          clear,
   output rsp_type       rsp
);

   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_FIRST = 3'd1;
   localparam logic [2:0] PH_TU    = 3'd2;
   localparam logic [2:0] PH_UEGP  = 3'd3;
   localparam logic [2:0] PH_UEGS  = 3'd4;
   localparam logic [2:0] PH_SIGN  = 3'd5;

   logic [2:0]  phase_ff, phase_in;
   logic [7:0]  types_ff, types_in;
   logic [2:0]  count_ff, count_in;
   logic [1:0]  sub_ff, sub_in;
   logic [1:0]  part_ff, part_in;
   logic        axis_ff, axis_in;
   logic [4:0]  prefix_ff, prefix_in;
   logic [4:0]  suffix_ff, suffix_in;
   logic [31:0] accum_ff, accum_in;
   abs_type     x_abs_ff, x_abs_in;

   logic        do_complete;
   logic        do_fail;
   logic        start;
   logic [31:0] cval;
   abs_type     cabs;
   logic [2:0]  cnt;
   logic [4:0]  sb;
   logic [31:0] ssum;

   always_comb begin
      phase_in  = phase_ff;
      types_in  = types_ff;
      count_in  = count_ff;
      sub_in    = sub_ff;
      part_in   = part_ff;
      axis_in   = axis_ff;
      prefix_in = prefix_ff;
      suffix_in = suffix_ff;
      accum_in  = accum_ff;
      x_abs_in  = x_abs_ff;
      rsp         = '0;
      wr          = '0;
      clear       = 1'b0;
      do_complete = 1'b0;
      do_fail     = 1'b0;
      start       = 1'b0;
      cval        = '0;
      cabs        = '0;
      cnt         = (sub_count > 3'(SUB_BLOCKS)) ? 3'(SUB_BLOCKS) : sub_count;
      sb          = (suffix_ff != 5'd0) ? suffix_ff - 5'd1 : 5'd0;
      ssum        = accum_ff + ({31'd0, bin_value} << sb);

      if (accept) begin
         if (action == ACT_BEGIN) begin
            types_in  = sub_types;
            count_in  = cnt;
            sub_in    = '0;
            part_in   = '0;
            axis_in   = 1'b0;
            prefix_in = '0;
            suffix_in = '0;
            accum_in  = '0;
            x_abs_in  = '0;
            clear     = 1'b1;
            if (cnt == 3'd0) begin
               phase_in = PH_IDLE;
               rsp.last = 1'b1;
            end else begin
               start = 1'b1;
            end
         end else begin
            case (phase_ff)
               PH_FIRST: begin
                  if (!bin_value) begin
                     do_complete = 1'b1;
                  end else begin
                     prefix_in    = 5'd1;
                     phase_in     = PH_TU;
                     rsp.next_ctx = ctx_base(axis_ff) + tu_offset(3'd0);
                  end
               end
               PH_TU: begin
                  if (!bin_value) begin
                     accum_in        = {27'd0, prefix_ff};
                     phase_in        = PH_SIGN;
                     rsp.next_bypass = 1'b1;
                  end else if (prefix_ff >= TU_EXTRA) begin
                     prefix_in       = '0;
                     suffix_in       = UEG_ORDER;
                     accum_in        = '0;
                     phase_in        = PH_UEGP;
                     rsp.next_bypass = 1'b1;
                  end else begin
                     prefix_in    = prefix_ff + 5'd1;
                     rsp.next_ctx = ctx_base(axis_ff) + tu_offset(prefix_ff[2:0]);
                  end
               end
               PH_UEGP: begin
                  if (!bin_value) begin
                     phase_in        = PH_UEGS;
                     rsp.next_bypass = 1'b1;
                  end else if (prefix_ff >= 5'(MAX_PREFIX_ONES)) begin
                     do_fail = 1'b1;
                  end else begin
                     accum_in        = accum_ff + (32'd1 << suffix_ff);
                     suffix_in       = suffix_ff + 5'd1;
                     prefix_in       = prefix_ff + 5'd1;
                     rsp.next_bypass = 1'b1;
                  end
               end
               PH_UEGS: begin
                  suffix_in = sb;
                  accum_in  = ssum;
                  if (sb == 5'd0) begin
                     if (ssum > VALUE_MAX - UEG_OFFSET) begin
                        do_fail = 1'b1;
                     end else begin
                        accum_in        = ssum + UEG_OFFSET;
                        phase_in        = PH_SIGN;
                        rsp.next_bypass = 1'b1;
                     end
                  end else begin
                     rsp.next_bypass = 1'b1;
                  end
               end
               PH_SIGN: begin
                  do_complete = 1'b1;
                  cval        = bin_value ? (32'd0 - accum_ff) : accum_ff;
                  cabs        = sat_abs(accum_ff);
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end

      if (do_fail) begin
         rsp.mvd_axis   = axis_ff;
         rsp.sub_block  = sub_ff;
         rsp.part_index = part_ff;
         rsp.error_flag = 1'b1;
         rsp.last       = 1'b1;
         phase_in       = PH_IDLE;
      end

      if (do_complete) begin
         rsp.mvd_valid  = 1'b1;
         rsp.mvd_value  = cval;
         rsp.mvd_axis   = axis_ff;
         rsp.sub_block  = sub_ff;
         rsp.part_index = part_ff;
         if (!axis_ff) begin
            x_abs_in = cabs;
            axis_in  = 1'b1;
            start    = 1'b1;
         end else begin
            wr.en    = 1'b1;
            wr.sub   = sub_ff;
            wr.x_abs = x_abs_ff;
            wr.y_abs = cabs;
            axis_in  = 1'b0;
            if (({1'b0, part_ff} + 3'd1) < parts_of(type_of(types_ff, sub_ff))) begin
               part_in = part_ff + 2'd1;
               start   = 1'b1;
            end else begin
               part_in = '0;
               if (({1'b0, sub_ff} + 3'd1) >= count_ff) begin
                  rsp.last = 1'b1;
                  phase_in = PH_IDLE;
               end else begin
                  sub_in = sub_ff + 2'd1;
                  start  = 1'b1;
               end
            end
         end
      end

      if (start) begin
         phase_in     = PH_FIRST;
         rsp.next_ctx = ctx_base(axis_in) + {4'd0, inc};
      end

      query.sub       = sub_in;
      query.axis      = axis_in;
      query.type_zero = (type_of(types_in, sub_in) == 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         types_ff  <= '0;
         count_ff  <= '0;
         sub_ff    <= '0;
         part_ff   <= '0;
         axis_ff   <= 1'b0;
         prefix_ff <= '0;
         suffix_ff <= '0;
         accum_ff  <= '0;
         x_abs_ff  <= '0;
      end else begin
         phase_ff  <= phase_in;
         types_ff  <= types_in;
         count_ff  <= count_in;
         sub_ff    <= sub_in;
         part_ff   <= part_in;
         axis_ff   <= axis_in;
         prefix_ff <= prefix_in;
         suffix_ff <= suffix_in;
         accum_ff  <= accum_in;
         x_abs_ff  <= x_abs_in;
      end
   end

endmodule

FILE: rtl/mvd_oreg.sv
module mvd_oreg
   import mvd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type rsp_in,
   input  logic    out_ready,
   output logic    in_ready,
   output logic    out_valid,
   output rsp_type rsp_out
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign rsp_out   = data_ff;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // hold the result until taken
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= rsp_in;
      end
   end

endmodule

FILE: rtl/mvd_ueg3_debinarizer.sv
// channel  direction  handshake               payload
// req      in         req_valid / req_ready   action, sub_types, sub_count, bin_value
// rsp      out        rsp_valid / rsp_ready   next_ctx, next_bypass, mvd_*, sub_block,
//                                             part_index, error_flag, last
//
// Each request gives one response, valid in the cycle after it is accepted; a request can
// be accepted every cycle. The bin state machine and the neighbor store update
// in the accept cycle, and the response sits in an output register.
// A held response stalls the input only while rsp_ready is low.
// Synchronous reset returns to idle and empties the output register.
module mvd_ueg3_debinarizer
   import mvd_pkg::*;
#(
   parameter int MAX_PREFIX_ONES = MAX_PREFIX_ONES_DEF
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_action,
   input  logic [7:0]         req_sub_types,
   input  logic [2:0]         req_sub_count,
   input  logic               req_bin_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [5:0]         rsp_next_ctx,
   output logic               rsp_next_bypass,
   output logic               rsp_mvd_valid,
   output logic signed [31:0] rsp_mvd_value,
   output logic               rsp_mvd_axis,
   output logic [1:0]         rsp_sub_block,
   output logic [1:0]         rsp_part_index,
   output logic               rsp_error_flag,
   output logic               rsp_last
);

   logic          accept;
   logic [1:0]    inc;
   logic          clear;
   nbr_query_type query;
   nbr_write_type wr;
   rsp_type       rsp_next;
   rsp_type       rsp_q;

   assign accept = req_valid && req_ready;

   mvd_ctrl #(
      .MAX_PREFIX_ONES(MAX_PREFIX_ONES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .action    (req_action),
      .sub_types (req_sub_types),
      .sub_count (req_sub_count),
      .bin_value (req_bin_value),
      .inc       (inc),
      .query     (query),
      .wr        (wr),
      .clear     (clear),
      .rsp       (rsp_next)
   );

   mvd_nbr u_nbr (
      .clock (clock),
      .reset (reset),
      .clear (clear),
      .wr    (wr),
      .query (query),
      .inc   (inc)
   );

   mvd_oreg u_oreg (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .rsp_in    (rsp_next),
      .out_ready (rsp_ready),
      .in_ready  (req_ready),
      .out_valid (rsp_valid),
      .rsp_out   (rsp_q)
   );

   assign rsp_next_ctx    = rsp_q.next_ctx;
   assign rsp_next_bypass = rsp_q.next_bypass;
   assign rsp_mvd_valid   = rsp_q.mvd_valid;
   assign rsp_mvd_value   = rsp_q.mvd_value;
   assign rsp_mvd_axis    = rsp_q.mvd_axis;
   assign rsp_sub_block   = rsp_q.sub_block;
   assign rsp_part_index  = rsp_q.part_index;
   assign rsp_error_flag  = rsp_q.error_flag;
   assign rsp_last        = rsp_q.last;

endmodule

FILE: sim/mvd_ueg3_debinarizer_test.sv
module mvd_ueg3_debinarizer_test;
   import mvd_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_ITEMS = 1250;

   typedef enum logic [2:0] {
      DS_IDLE, DS_FIRST, DS_PREFIX, DS_EXP_PREFIX, DS_EXP_SUFFIX, DS_SIGN
   } dec_state_type;

   typedef enum logic [1:0] {RX_ALWAYS, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_mode_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic               req_action;
   logic [7:0]         req_sub_types;
   logic [2:0]         req_sub_count;
   logic               req_bin_value;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [5:0]         rsp_next_ctx;
   logic               rsp_next_bypass;
   logic               rsp_mvd_valid;
   logic signed [31:0] rsp_mvd_value;
   logic               rsp_mvd_axis;
   logic [1:0]         rsp_sub_block;
   logic [1:0]         rsp_part_index;
   logic               rsp_error_flag;
   logic               rsp_last;

   mvd_ueg3_debinarizer uut (
      .clock, .reset,
      .req_valid, .req_ready, .req_action, .req_sub_types, .req_sub_count, .req_bin_value,
      .rsp_valid, .rsp_ready, .rsp_next_ctx, .rsp_next_bypass, .rsp_mvd_valid,
      .rsp_mvd_value, .rsp_mvd_axis, .rsp_sub_block, .rsp_part_index, .rsp_error_flag,
      .rsp_last
   );

   // decoder state mirrored by the predictor
   dec_state_type dec_phase;
   logic [7:0]  mb_types;
   logic [2:0]  mb_count;
   logic [1:0]  sub_at;
   logic [1:0]  part_at;
   logic        axis_at;
   logic [5:0]  ctx_base_at;
   int unsigned ones_seen;
   int unsigned suffix_len;
   logic [31:0] magnitude;
   logic [31:0] x_saved;
   logic [31:0] nbr_x [4];
   logic [31:0] nbr_y [4];
   logic        nbr_ok [4];
   rsp_type     step_rsp;

   rsp_type pending_rsp [$];

   int fail_count;
   int real_items;
   int ignored_bins;
   int mvd_count;
   int error_count;
   int mb_closed;
   int input_stall_cycles;
   int cycle_count;
   int hold_off_len;
   int burst_left;
   bit steady_sender;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycle_count, pending_rsp.size());
      $display("[FAIL] regression broken");
      $finish;
   end

   // ---------------------------------------------------------------- predictor

   function automatic int unsigned sub_type(input logic [1:0] s);
      return (mb_types >> (2 * s)) & 8'd3;
   endfunction

   function automatic int unsigned part_total(input int unsigned t);
      if (t == 0) return 1;
      if (t == 3) return 4;
      return 2;
   endfunction

   function automatic logic [5:0] tu_step(input int unsigned i);
      logic [5:0] r;
      r = 6'd3 + i[5:0];
      if (i >= 3) r = 6'd6;
      return r;
   endfunction

   function automatic longint unsigned mag_of(input logic [31:0] v);
      return {32'd0, v[31] ? (~v + 32'd1) : v};
   endfunction

   // left neighbor is sub-block s-1 for odd s, top neighbor is s-2 for the lower row
   function automatic logic [5:0] ctx_increment();
      longint unsigned sum;
      sum = 0;
      if (sub_type(sub_at) != 0) return 6'd0;
      if (sub_at[0] && nbr_ok[sub_at - 1])
         sum += mag_of(axis_at ? nbr_y[sub_at - 1] : nbr_x[sub_at - 1]);
      if (sub_at[1] && nbr_ok[sub_at - 2])
         sum += mag_of(axis_at ? nbr_y[sub_at - 2] : nbr_x[sub_at - 2]);
      if (sum < ABS_LIMIT_LOW) return 6'd0;
      if (sum <= ABS_LIMIT_HIGH) return 6'd1;
      return 6'd2;
   endfunction

   function automatic logic [5:0] open_component();
      ctx_base_at = axis_at ? CTX_BASE_Y : CTX_BASE_X;
      dec_phase = DS_FIRST;
      return ctx_base_at + ctx_increment();
   endfunction

   function automatic void mark_position();
      step_rsp.mvd_axis = axis_at;
      step_rsp.sub_block = sub_at;
      step_rsp.part_index = part_at;
   endfunction

   function automatic void abort_mb();
      mark_position();
      step_rsp.error_flag = 1'b1;
      step_rsp.last = 1'b1;
      dec_phase = DS_IDLE;
   endfunction

   function automatic void finish_component(input logic [31:0] v);
      step_rsp.mvd_valid = 1'b1;
      step_rsp.mvd_value = v;
      mark_position();
      if (!axis_at) begin
         x_saved = v;
         axis_at = 1'b1;
         step_rsp.next_ctx = open_component();
         return;
      end
      nbr_x[sub_at] = x_saved;
      nbr_y[sub_at] = v;
      nbr_ok[sub_at] = 1'b1;
      axis_at = 1'b0;
      if (part_at + 1 < part_total(sub_type(sub_at))) begin
         part_at++;
      end else begin
         part_at = 2'd0;
         if (sub_at + 1 >= mb_count) begin
            step_rsp.last = 1'b1;
            dec_phase = DS_IDLE;
            return;
         end
         sub_at++;
      end
      step_rsp.next_ctx = open_component();
   endfunction

   function automatic rsp_type mvd_decode_step(input logic act, input logic [7:0] types,
                                                input logic [2:0] cnt, input logic bin);
      step_rsp = '0;
      if (act == ACT_BEGIN) begin
         mb_types = types;
         mb_count = (cnt > 3'(SUB_BLOCKS)) ? 3'(SUB_BLOCKS) : cnt;
         sub_at = 2'd0;
         part_at = 2'd0;
         axis_at = 1'b0;
         ones_seen = 0;
         suffix_len = 0;
         magnitude = 32'd0;
         x_saved = 32'd0;
         for (int i = 0; i < 4; i++) nbr_ok[i] = 1'b0;
         if (mb_count == 0) begin
            dec_phase = DS_IDLE;
            step_rsp.last = 1'b1;
         end else begin
            step_rsp.next_ctx = open_component();
         end
         return step_rsp;
      end
      case (dec_phase)
         DS_FIRST: begin
            if (!bin) begin
               finish_component(32'd0);
            end else begin
               ones_seen = 1;
               dec_phase = DS_PREFIX;
               step_rsp.next_ctx = ctx_base_at + tu_step(0);
            end
         end
         DS_PREFIX: begin
            if (!bin) begin
               magnitude = ones_seen;
               dec_phase = DS_SIGN;
               step_rsp.next_bypass = 1'b1;
            end else if (ones_seen >= TU_EXTRA) begin
               ones_seen = 0;
               suffix_len = 32'(UEG_ORDER);
               magnitude = 32'd0;
               dec_phase = DS_EXP_PREFIX;
               step_rsp.next_bypass = 1'b1;
            end else begin
               ones_seen++;
               step_rsp.next_ctx = ctx_base_at + tu_step(ones_seen - 1);
            end
         end
         DS_EXP_PREFIX: begin
            if (!bin) begin
               dec_phase = DS_EXP_SUFFIX;
               step_rsp.next_bypass = 1'b1;
            end else if (ones_seen >= MAX_PREFIX_ONES_DEF) begin
               abort_mb();
            end else begin
               magnitude += 32'd1 << suffix_len;
               suffix_len++;
               ones_seen++;
               step_rsp.next_bypass = 1'b1;
            end
         end
         DS_EXP_SUFFIX: begin
            if (suffix_len > 0) suffix_len--;
            magnitude += {31'd0, bin} << suffix_len;
            if (suffix_len != 0) begin
               step_rsp.next_bypass = 1'b1;
            end else if (magnitude > VALUE_MAX - UEG_OFFSET) begin
               abort_mb();
            end else begin
               magnitude += UEG_OFFSET;
               dec_phase = DS_SIGN;
               step_rsp.next_bypass = 1'b1;
            end
         end
         DS_SIGN: finish_component(bin ? (~magnitude + 32'd1) : magnitude);
         default: dec_phase = DS_IDLE;
      endcase
      return step_rsp;
   endfunction

   // ---------------------------------------------------------------- driving

   task automatic send_req(input logic act, input logic [7:0] types,
                           input logic [2:0] cnt, input logic bin);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 24);
         gap = $urandom_range(0, 6);
         if (!steady_sender && gap > 0) begin
            @(negedge clock);
            req_valid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid = 1'b1;
      req_action = act;
      req_sub_types = types;
      req_sub_count = cnt;
      req_bin_value = bin;
      forever begin
         @(posedge clock);
         if (req_ready) break;
      end
      if (act == ACT_BIN && dec_phase == DS_IDLE) ignored_bins++;
      else real_items++;
      pending_rsp.push_back(mvd_decode_step(act, types, cnt, bin));
   endtask

   task automatic send_bin(input logic bin);
      send_req(ACT_BIN, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)), bin);
   endtask

   task automatic send_begin(input logic [7:0] types, input logic [2:0] cnt);
      send_req(ACT_BEGIN, types, cnt, 1'($urandom_range(0, 1)));
   endtask

   // binarize one mvd component: TU prefix, UEG3 suffix, sign
   task automatic send_mvd(input longint value);
      longint unsigned mag;
      longint unsigned rest;
      int bits;
      mag = (value < 0) ? -value : value;
      if (mag == 0) begin
         send_bin(1'b0);
         return;
      end
      send_bin(1'b1);
      if (mag < 9) begin
         repeat (mag - 1) send_bin(1'b1);
         send_bin(1'b0);
      end else begin
         repeat (8) send_bin(1'b1);
         rest = mag - 9;
         bits = 3;
         while (rest >= (64'd1 << bits)) begin
            rest -= 64'd1 << bits;
            bits++;
            send_bin(1'b1);
         end
         send_bin(1'b0);
         for (int i = bits - 1; i >= 0; i--) send_bin(rest[i]);
      end
      send_bin(value < 0);
   endtask

   function automatic longint pick_mvd();
      int r;
      longint mag;
      r = $urandom_range(0, 99);
      if (r < 25) mag = 0;
      else if (r < 60) mag = longint'($urandom_range(1, 8));
      else if (r < 85) mag = longint'($urandom_range(9, 64));
      else if (r < 95) mag = longint'($urandom_range(65, 65535));
      else if (r < 99) mag = longint'($urandom_range(65536, 32'h7FFF_FFFF));
      else mag = 32'h7FFF_FFFF;
      return $urandom_range(0, 1) ? -mag : mag;
   endfunction

   // random bin; favours ones in DS_PREFIX, and in DS_EXP_PREFIX if long_prefix
   function automatic logic noise_bin(input bit long_prefix);
      case (dec_phase)
         DS_PREFIX:     return $urandom_range(0, 9) < 7;
         DS_EXP_PREFIX: return long_prefix ? ($urandom_range(0, 99) < 97)
                                           : ($urandom_range(0, 1) == 1);
         default:       return 1'($urandom_range(0, 1));
      endcase
   endfunction

   task automatic run_macroblock();
      int r;
      logic [2:0] cnt;
      bit long_prefix;
      r = $urandom_range(0, 99);
      if (r < 4) cnt = 3'd0;
      else if (r < 10) cnt = 3'($urandom_range(5, 7));
      else cnt = 3'($urandom_range(1, 4));
      long_prefix = ($urandom_range(0, 19) == 0);
      if ($urandom_range(0, 29) == 0) send_bin(1'($urandom_range(0, 1)));
      send_begin(8'($urandom_range(0, 255)), cnt);
      while (dec_phase != DS_IDLE) begin
         if (dec_phase == DS_FIRST) begin
            r = $urandom_range(0, 99);
            // drop the macroblock; the next begin restarts mid-flight
            if (r < 3) return;
            if (r < 90) send_mvd(pick_mvd());
            else send_bin(noise_bin(long_prefix));
         end else begin
            send_bin(noise_bin(long_prefix));
         end
      end
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_idle_bins();
      send_bin(1'b0);
      send_bin(1'b1);
   endtask

   task automatic test_count_limits();
      send_begin(8'hFF, 3'd0);
      send_begin(8'h00, 3'd7);
      repeat (8) send_mvd(0);
   endtask

   // neighbor sums landing below 3, exactly 3, exactly 32 and above 32
   task automatic test_neighbour_contexts();
      send_begin(8'h00, 3'd5);
      send_mvd(5);
      send_mvd(-40);
      send_mvd(-1);
      send_mvd(30);
      send_mvd(2);
      send_mvd(2);
      send_mvd(0);
      send_mvd(0);
   endtask

   task automatic test_other_types_and_restart();
      send_begin(8'b11_10_01_00, 3'd4);
      send_mvd(20);
      send_mvd(-20);
      send_mvd(0);
      send_mvd(0);
      send_mvd(1);
      send_mvd(-1);
      send_mvd(3);
      send_mvd(0);
      send_bin(1'b1);
      send_begin(8'h0C, 3'd2);
      send_mvd(-7);
      send_mvd(7);
      send_mvd(0);
      send_mvd(1);
      send_mvd(2);
      send_mvd(0);
      send_mvd(0);
      send_mvd(0);
      send_mvd(-1);
      send_mvd(-1);
   endtask

   task automatic test_extreme_values();
      send_begin(8'h00, 3'd1);
      send_mvd(64'sd2147483647);
      send_mvd(-64'sd2147483647);
      send_begin(8'h00, 3'd1);
      send_mvd(8);
      send_mvd(-9);
   endtask

   task automatic test_prefix_too_long();
      send_begin(8'h00, 3'd1);
      repeat (9) send_bin(1'b1);
      repeat (MAX_PREFIX_ONES_DEF + 1) send_bin(1'b1);
      send_bin(1'b0);
   endtask

   task automatic test_suffix_overflow();
      send_begin(8'h00, 3'd1);
      repeat (9) send_bin(1'b1);
      repeat (MAX_PREFIX_ONES_DEF) send_bin(1'b1);
      send_bin(1'b0);
      repeat (30) send_bin(1'b1);
   endtask

   task automatic test_backpressure();
      steady_sender = 1'b1;
      hold_off_len = 80;
      send_begin(8'hFF, 3'd4);
      repeat (16) send_mvd(longint'($urandom_range(0, 20)) - 10);
      // drop valid so the last request is not taken again while waiting
      @(negedge clock);
      req_valid = 1'b0;
      while (hold_off_len != 0) @(posedge clock);
      steady_sender = 1'b0;
   endtask

   task automatic test_random_stream();
      int goal;
      goal = real_items + RANDOM_ITEMS;
      while (real_items < goal) run_macroblock();
   endtask

   // ---------------------------------------------------------------- receiver

   initial begin
      rx_mode_type mode;
      int span;
      int period;
      int tick;
      rsp_ready = 1'b0;
      mode = RX_ALWAYS;
      span = 0;
      period = 3;
      tick = 0;
      forever begin
         @(negedge clock);
         if (hold_off_len != 0) begin
            rsp_ready = 1'b0;
            repeat (hold_off_len - 1) @(negedge clock);
            hold_off_len = 0;
         end else begin
            if (span == 0) begin
               case ($urandom_range(0, 3))
                  0:       mode = RX_ALWAYS;
                  1:       mode = RX_MOSTLY;
                  2:       mode = RX_SPARSE;
                  default: mode = RX_PERIODIC;
               endcase
               span = $urandom_range(20, 150);
               period = $urandom_range(2, 7);
            end
            span--;
            tick++;
            case (mode)
               RX_ALWAYS:   rsp_ready = 1'b1;
               RX_MOSTLY:   rsp_ready = ($urandom_range(0, 3) != 0);
               RX_SPARSE:   rsp_ready = ($urandom_range(0, 9) < 3);
               RX_PERIODIC: rsp_ready = ((tick % period) != 0);
            endcase
         end
      end
   end

   // ---------------------------------------------------------------- checker

   function automatic string rsp_text(input rsp_type r);
      return $sformatf("ctx=%0d byp=%0b mv=%0b val=%0d axis=%0b sub=%0d part=%0d err=%0b last=%0b",
                       r.next_ctx, r.next_bypass, r.mvd_valid, r.mvd_value, r.mvd_axis,
                       r.sub_block, r.part_index, r.error_flag, r.last);
   endfunction

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      logic same;
      if (!reset && req_valid && !req_ready) input_stall_cycles++;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_next_ctx, rsp_next_bypass, rsp_mvd_valid, rsp_mvd_value, rsp_mvd_axis,
                rsp_sub_block, rsp_part_index, rsp_error_flag, rsp_last};
         if (pending_rsp.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("cycle %0d: response with no request pending: %s",
                        cycle_count, rsp_text(got));
         end else begin
            want = pending_rsp.pop_front();
            same = got.next_ctx === want.next_ctx && got.next_bypass === want.next_bypass
                   && got.mvd_valid === want.mvd_valid && got.mvd_value === want.mvd_value
                   && got.mvd_axis === want.mvd_axis && got.sub_block === want.sub_block
                   && got.part_index === want.part_index
                   && got.error_flag === want.error_flag && got.last === want.last;
            if (!same) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("cycle %0d: mismatch", cycle_count);
                  $display("   expected %s", rsp_text(want));
                  $display("   actual   %s", rsp_text(got));
               end
            end
            if (want.mvd_valid) mvd_count++;
            if (want.error_flag) error_count++;
            if (want.last) mb_closed++;
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      req_valid = 1'b0;
      req_action = ACT_BIN;
      req_sub_types = 8'd0;
      req_sub_count = 3'd0;
      req_bin_value = 1'b0;
      reset = 1'b1;
      fail_count = 0;
      real_items = 0;
      ignored_bins = 0;
      mvd_count = 0;
      error_count = 0;
      mb_closed = 0;
      input_stall_cycles = 0;
      hold_off_len = 0;
      burst_left = 0;
      steady_sender = 1'b0;
      dec_phase = DS_IDLE;
      mb_types = 8'd0;
      mb_count = 3'd0;
      sub_at = 2'd0;
      part_at = 2'd0;
      axis_at = 1'b0;
      ctx_base_at = 6'd0;
      ones_seen = 0;
      suffix_len = 0;
      magnitude = 32'd0;
      x_saved = 32'd0;
      for (int i = 0; i < 4; i++) begin
         nbr_x[i] = 32'd0;
         nbr_y[i] = 32'd0;
         nbr_ok[i] = 1'b0;
      end
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_idle_bins();
      test_count_limits();
      test_neighbour_contexts();
      test_other_types_and_restart();
      test_extreme_values();
      test_prefix_too_long();
      test_suffix_overflow();
      test_backpressure();
      test_random_stream();

      @(negedge clock);
      req_valid = 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("covered %0d requests plus %0d bins while idle: %0d mvd components, %0d ends",
               real_items, ignored_bins, mvd_count, mb_closed);
      $display("%0d error aborts, input stalled %0d cycles by output back-pressure",
               error_count, input_stall_cycles);
      if (fail_count == 0 && pending_rsp.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
